@@ hdl/tdq_pkg.sv @@
`default_nettype none

package tdq_pkg;

    // result kinds
    localparam logic [1:0] KIND_EXPIRED  = 2'd0;
    localparam logic [1:0] KIND_TICK     = 2'd1;
    localparam logic [1:0] KIND_ADDED    = 2'd2;
    localparam logic [1:0] KIND_REJECTED = 2'd3;

    // input commands
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    // configuration register indexes
    localparam logic CFG_TASK_MARKER = 1'b0;
    localparam logic CFG_TASK_PERIOD = 1'b1;

    localparam logic [31:0] TASK_MARKER_RST = 32'h7fff_ffff;
    localparam logic [15:0] TASK_PERIOD_RST = 16'd2;

    typedef struct packed {
        logic               command;
        logic        [63:0] timer_deadline;
        logic signed [31:0] timer_value;
    } t_in;

    typedef struct packed {
        logic        [1:0]  result_kind;
        logic        [63:0] expired_deadline;
        logic signed [31:0] expired_value;
        logic               task_switch;
        logic               last_result;
    } t_out;

    // one pending timer as held in a cell
    typedef struct packed {
        logic               valid;
        logic        [63:0] deadline;
        logic signed [31:0] value;
    } t_entry;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_SHIFT,
        OP_INSERT
    } t_cell_op;

    // command broadcast to every cell of the row
    typedef struct packed {
        t_cell_op op;
        t_entry   ins;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ hdl/tdq_cell.sv @@
`default_nettype none

module tdq_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tdq_pkg::t_cell_ctl i_ctl,
    input  wire tdq_pkg::t_entry    i_left,
    input  wire logic               i_left_gt,
    input  wire tdq_pkg::t_entry    i_right,
    output tdq_pkg::t_entry         o_entry,
    output logic                    o_gt
);

    tdq_pkg::t_entry r_entry;
    tdq_pkg::t_entry n_entry;

    // an empty cell sorts after every deadline
    assign o_gt    = !r_entry.valid || (r_entry.deadline > i_ctl.ins.deadline);
    assign o_entry = r_entry;

    // pick next content: shift toward the head, or make room for an insert
    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            tdq_pkg::OP_SHIFT: begin
                n_entry = i_right;
            end
            tdq_pkg::OP_INSERT: begin
                if (i_left_gt) begin
                    n_entry = i_left;
                end else if (o_gt) begin
                    n_entry = i_ctl.ins;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // clear the valid flag on reset; data needs no reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
        r_entry.deadline <= n_entry.deadline;
        r_entry.value    <= n_entry.value;
    end

endmodule

`default_nettype wire

@@ hdl/timer_deadline_queue.sv @@
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        input      i_in_valid / o_in_stall  i_in  (tdq_pkg::t_in)
// out       output     o_out_valid / i_out_stall o_out (tdq_pkg::t_out)
// cfg       input      i_cfg_we                i_cfg_index, i_cfg_data
//
// Timers sit in a row of cells kept sorted by deadline, ties in insertion order.
// An add inserts into the row, then gives the reply.
// A tick pops due timers, re-arms the task timers and replies; the row pops one
// head entry per cycle unless the output stalls, and re-inserts one per cycle.
// Reset clears the row and tick counter and loads config registers with defaults.
// A stalled output holds only a step that issues a result; no transaction is lost.

module timer_deadline_queue #(
    parameter int TIMER_SLOTS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire tdq_pkg::t_in    i_in,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output tdq_pkg::t_out        o_out,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [31:0]     i_cfg_data
);

    localparam int CW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REPLY,
        S_POP,
        S_REARM,
        S_DONE
    } t_state;

    t_state                 r_state, n_state;
    logic            [63:0] r_tick, n_tick;
    logic            [1:0]  r_reply_kind, n_reply_kind;
    logic            [CW-1:0] r_rearm_cnt, n_rearm_cnt;
    logic                   r_sw, n_sw;
    logic            [63:0] r_next;
    logic                   r_out_valid, n_out_valid;
    tdq_pkg::t_out          r_out, n_out;
    logic signed     [31:0] r_task_marker;
    logic            [15:0] r_task_period;

    tdq_pkg::t_cell_ctl     w_ctl;
    tdq_pkg::t_entry        w_entry [TIMER_SLOTS];
    logic                   w_gt    [TIMER_SLOTS];
    tdq_pkg::t_entry        w_head;
    logic                   w_full;
    logic                   w_accept;
    logic                   w_slot_free;
    logic                   w_due;
    logic            [15:0] w_period;
    logic            [64:0] w_sum;
    logic            [63:0] w_next;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_marker <= tdq_pkg::TASK_MARKER_RST;
            r_task_period <= tdq_pkg::TASK_PERIOD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tdq_pkg::CFG_TASK_MARKER: r_task_marker <= i_cfg_data;
                tdq_pkg::CFG_TASK_PERIOD: r_task_period <= i_cfg_data[15:0];
                default: r_task_marker <= r_task_marker;
            endcase
        end
    end

    // re-arm deadline: count plus period, zero period acts as one, saturate
    assign w_period = (r_task_period == 16'd0) ? 16'd1 : r_task_period;
    assign w_sum    = {1'b0, r_tick} + {49'd0, w_period};
    assign w_next   = w_sum[64] ? {64{1'b1}} : w_sum[63:0];

    // row of cells, head at index 0
    genvar g;
    generate
        for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
            tdq_pkg::t_entry w_left;
            tdq_pkg::t_entry w_right;
            logic            w_left_gt;

            if (g == 0) begin : g_head
                assign w_left    = '{valid: 1'b1, deadline: 64'd0, value: 32'sd0};
                assign w_left_gt = 1'b0;
            end else begin : g_mid
                assign w_left    = w_entry[g-1];
                assign w_left_gt = w_gt[g-1];
            end

            if (g == TIMER_SLOTS - 1) begin : g_tail
                assign w_right = '{valid: 1'b0, deadline: 64'd0, value: 32'sd0};
            end else begin : g_body
                assign w_right = w_entry[g+1];
            end

            tdq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_left    (w_left),
                .i_left_gt (w_left_gt),
                .i_right   (w_right),
                .o_entry   (w_entry[g]),
                .o_gt      (w_gt[g])
            );
        end
    endgenerate

    assign w_head      = w_entry[0];
    assign w_full      = w_entry[TIMER_SLOTS-1].valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_due       = w_head.valid && (w_head.deadline <= r_tick);

    // sequence one transaction: insert, pop due timers, re-arm, report
    always_comb begin
        n_state      = r_state;
        n_tick       = r_tick;
        n_reply_kind = r_reply_kind;
        n_rearm_cnt  = r_rearm_cnt;
        n_sw         = r_sw;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out        = r_out;
        w_ctl.op     = tdq_pkg::OP_HOLD;
        w_ctl.ins    = '{valid: 1'b1, deadline: i_in.timer_deadline, value: i_in.timer_value};

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in.command == tdq_pkg::CMD_ADD) begin
                        n_state = S_REPLY;
                        if (w_full) begin
                            n_reply_kind = tdq_pkg::KIND_REJECTED;
                        end else begin
                            n_reply_kind = tdq_pkg::KIND_ADDED;
                            w_ctl.op     = tdq_pkg::OP_INSERT;
                        end
                    end else begin
                        n_state     = S_POP;
                        n_tick      = r_tick + 64'd1;
                        n_rearm_cnt = '0;
                        n_sw        = 1'b0;
                    end
                end
            end
            S_REPLY: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: r_reply_kind, expired_deadline: 64'd0,
                                    expired_value: 32'sd0, task_switch: 1'b0,
                                    last_result: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_POP: begin
                if (!w_due) begin
                    n_state = S_REARM;
                end else if (w_head.value == r_task_marker) begin
                    w_ctl.op    = tdq_pkg::OP_SHIFT;
                    n_rearm_cnt = r_rearm_cnt + CW'(1);
                    n_sw        = 1'b1;
                end else if (w_slot_free) begin
                    w_ctl.op    = tdq_pkg::OP_SHIFT;
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: tdq_pkg::KIND_EXPIRED,
                                    expired_deadline: w_head.deadline,
                                    expired_value: w_head.value, task_switch: 1'b0,
                                    last_result: 1'b0};
                end
            end
            S_REARM: begin
                w_ctl.ins = '{valid: 1'b1, deadline: r_next, value: r_task_marker};
                if (r_rearm_cnt != '0) begin
                    w_ctl.op    = tdq_pkg::OP_INSERT;
                    n_rearm_cnt = r_rearm_cnt - CW'(1);
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{result_kind: tdq_pkg::KIND_TICK, expired_deadline: 64'd0,
                                    expired_value: 32'sd0, task_switch: r_sw,
                                    last_result: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= 64'd0;
            r_rearm_cnt <= '0;
            r_sw        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tick      <= n_tick;
            r_rearm_cnt <= n_rearm_cnt;
            r_sw        <= n_sw;
            r_out_valid <= n_out_valid;
        end
        r_reply_kind <= n_reply_kind;
        r_next       <= w_next;
        r_out        <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

@@ sim/tb_timer_deadline_queue.sv @@
`timescale 1ns / 100ps

module tb_timer_deadline_queue;

    localparam int SLOTS = 32;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    tdq_pkg::t_in  i_in        = '0;
    logic          i_out_stall = 1'b0;
    logic          i_cfg_we    = 1'b0;
    logic          i_cfg_index = tdq_pkg::CFG_TASK_MARKER;
    logic [31:0]   i_cfg_data  = '0;
    logic          o_in_stall;
    logic          o_out_valid;
    tdq_pkg::t_out o_out;

    // shadow of the block: configuration, tick counter and timer store
    logic [31:0] marker_cfg = tdq_pkg::TASK_MARKER_RST;
    logic [15:0] period_cfg = tdq_pkg::TASK_PERIOD_RST;
    logic [63:0] tick_cnt   = '0;
    logic [63:0] slot_dl [SLOTS];
    logic [31:0] slot_val [SLOTS];
    int          live_cnt   = 0;

    tdq_pkg::t_in  timer_cmds[$];
    tdq_pkg::t_out outstanding_results[$];

    // stimulus bookkeeping
    logic [63:0] ticks_sent = '0;
    int          far_left   = 8;
    int          tasks_left = 0;

    // handshake shaping
    int   in_gap     = 0;
    int   out_gap    = 0;
    int   hold_left  = 0;
    logic quiet      = 1'b0;
    logic press_go   = 1'b0;
    logic press_done = 1'b0;

    int   fail_cnt = 0;

    timer_deadline_queue #(
        .TIMER_SLOTS(SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Apply one command to the shadow store and queue the results it causes.
    task automatic apply_timer_cmd(input tdq_pkg::t_in cmd);
        tdq_pkg::t_out    r;
        logic [63:0]      step;
        logic [63:0]      rearm_at;
        logic [SLOTS-1:0] due;
        logic [SLOTS-1:0] gone;
        logic             sw;
        int               best;
        int               kept;
        int               rearms;
        int               i;
        r = '0;
        if (cmd.command == tdq_pkg::CMD_ADD) begin
            r.last_result = 1'b1;
            if (live_cnt >= SLOTS) begin
                r.result_kind = tdq_pkg::KIND_REJECTED;
            end else begin
                slot_dl[live_cnt]  = cmd.timer_deadline;
                slot_val[live_cnt] = cmd.timer_value;
                live_cnt++;
                r.result_kind = tdq_pkg::KIND_ADDED;
            end
            outstanding_results.push_back(r);
        end else begin
            tick_cnt = tick_cnt + 64'd1;
            step     = (period_cfg == 16'd0) ? 64'd1 : {48'd0, period_cfg};
            rearm_at = tick_cnt + step;
            if (rearm_at < tick_cnt)
                rearm_at = 64'hFFFF_FFFF_FFFF_FFFF;
            due    = '0;
            gone   = '0;
            sw     = 1'b0;
            rearms = 0;
            for (i = 0; i < live_cnt; i++)
                due[i] = (slot_dl[i] <= tick_cnt);
            // drain due timers earliest first, lowest slot wins a tie
            do begin
                best = -1;
                for (i = 0; i < live_cnt; i++) begin
                    if (due[i] && (best < 0 || slot_dl[i] < slot_dl[best]))
                        best = i;
                end
                if (best >= 0) begin
                    due[best]  = 1'b0;
                    gone[best] = 1'b1;
                    if (slot_val[best] == marker_cfg) begin
                        sw = 1'b1;
                        rearms++;
                    end else begin
                        r = '0;
                        r.result_kind      = tdq_pkg::KIND_EXPIRED;
                        r.expired_deadline = slot_dl[best];
                        r.expired_value    = slot_val[best];
                        outstanding_results.push_back(r);
                    end
                end
            end while (best >= 0);
            // compact survivors, then append re-armed task timers
            kept = 0;
            for (i = 0; i < live_cnt; i++) begin
                if (!gone[i]) begin
                    slot_dl[kept]  = slot_dl[i];
                    slot_val[kept] = slot_val[i];
                    kept++;
                end
            end
            for (i = 0; i < rearms && kept < SLOTS; i++) begin
                slot_dl[kept]  = rearm_at;
                slot_val[kept] = marker_cfg;
                kept++;
            end
            live_cnt = kept;
            r = '0;
            r.result_kind = tdq_pkg::KIND_TICK;
            r.task_switch = sw;
            r.last_result = 1'b1;
            outstanding_results.push_back(r);
        end
    endtask

    // Compare one result transaction with the oldest outstanding one.
    task automatic check_timer_result(input tdq_pkg::t_out got);
        tdq_pkg::t_out want;
        if (outstanding_results.size() == 0) begin
            fail_cnt++;
            if (fail_cnt <= 10)
                $display("unexpected result: kind %0d dl %h val %h sw %b last %b",
                         got.result_kind, got.expired_deadline, got.expired_value,
                         got.task_switch, got.last_result);
        end else begin
            want = outstanding_results.pop_front();
            if (got.result_kind !== want.result_kind ||
                got.expired_deadline !== want.expired_deadline ||
                got.expired_value !== want.expired_value ||
                got.task_switch !== want.task_switch ||
                got.last_result !== want.last_result) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display({"mismatch at %0t: exp kind %0d dl %h val %h sw %b last %b,",
                              " got kind %0d dl %h val %h sw %b last %b"},
                             $realtime, want.result_kind, want.expired_deadline,
                             want.expired_value, want.task_switch, want.last_result,
                             got.result_kind, got.expired_deadline, got.expired_value,
                             got.task_switch, got.last_result);
            end
        end
    endtask

    // Driver: offer queued commands, with random gaps between transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                apply_timer_cmd(i_in);
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (timer_cmds.size() > 0) begin
                    i_in       <= timer_cmds.pop_front();
                    i_in_valid <= 1'b1;
                    if (!quiet && $urandom_range(0, 4) == 0)
                        in_gap = $urandom_range(1, 3);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check results; stall in short bursts, once for a long stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall)
                check_timer_result(o_out);
            if (press_go && !press_done) begin
                press_done = 1'b1;
                hold_left  = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (out_gap > 0) begin
                out_gap--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                out_gap = $urandom_range(0, 2);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_add(input logic [63:0] dl, input logic [31:0] val);
        tdq_pkg::t_in it;
        it.command        = tdq_pkg::CMD_ADD;
        it.timer_deadline = dl;
        it.timer_value    = val;
        timer_cmds.push_back(it);
    endtask

    // Tick payload fields are ignored by the block; fill them with noise.
    task automatic push_tick();
        tdq_pkg::t_in it;
        it.command        = tdq_pkg::CMD_TICK;
        it.timer_deadline = {$urandom, $urandom};
        it.timer_value    = $urandom;
        timer_cmds.push_back(it);
        ticks_sent = ticks_sent + 64'd1;
    endtask

    // Mostly near deadlines so timers expire; a capped few never expire.
    function automatic logic [63:0] pick_deadline();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5 && far_left > 0) begin
            far_left--;
            if ($urandom_range(0, 1) == 0)
                return 64'hFFFF_FFFF_FFFF_FFFF;
            return {$urandom, $urandom} | 64'h8000_0000_0000_0000;
        end
        if (sel < 10)
            return 64'd0;
        if (sel < 20)
            return (ticks_sent >= 64'd4) ? ticks_sent - $urandom_range(0, 3) : ticks_sent;
        return ticks_sent + $urandom_range(1, 10);
    endfunction

    function automatic logic [31:0] pick_value();
        if (tasks_left > 0 && $urandom_range(0, 9) == 0) begin
            tasks_left--;
            return marker_cfg;
        end
        return $urandom;
    endfunction

    task automatic queue_random(input int count, input int add_pct, input int task_cap);
        tasks_left = task_cap;
        repeat (count) begin
            if ($urandom_range(0, 99) < add_pct)
                push_add(pick_deadline(), pick_value());
            else
                push_tick();
        end
    endtask

    // Write both registers back to back; upper period bits are noise.
    task automatic write_cfg(input logic [31:0] marker, input logic [15:0] period);
        logic [31:0] noise;
        noise = $urandom;
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= tdq_pkg::CFG_TASK_MARKER;
        i_cfg_data  <= marker;
        @(posedge i_clk);
        i_cfg_index <= tdq_pkg::CFG_TASK_PERIOD;
        i_cfg_data  <= {noise[31:16], period};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        marker_cfg = marker;
        period_cfg = period;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (timer_cmds.size() != 0 || i_in_valid || outstanding_results.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset config, extremes, ties, task re-arm
        push_tick();
        push_add(64'd0, 32'h8000_0000);
        push_add(64'd2, 32'h7fff_ffff);
        push_add(64'd2, 32'd5);
        push_add(64'd2, 32'hffff_ffff);
        push_add(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
        far_left--;
        push_add(64'd3, 32'h7fff_fffe);
        push_tick();
        push_tick();
        push_tick();
        push_add(64'd4, 32'd7);
        push_add(64'd6, 32'd9);
        push_add(64'd6, 32'd8);
        push_tick();
        push_tick();
        push_add(64'd7, 32'h7fff_ffff);
        push_tick();
        push_tick();
        push_tick();
        push_tick();
        wait_drained();

        // zero period acts as one; minimum marker
        write_cfg(32'h8000_0000, 16'd0);
        queue_random(100, 55, 4);
        wait_drained();

        // maximum period, random marker
        write_cfg($urandom, 16'hffff);
        queue_random(80, 50, 2);
        wait_drained();

        // fill the store while the receiver holds off, then drain it
        write_cfg(32'd0, 16'd1);
        press_go = 1'b1;
        push_add(ticks_sent + 64'd25, 32'd0);
        repeat (35)
            push_add(ticks_sent + $urandom_range(20, 40), $urandom | 32'd1);
        repeat (45)
            push_tick();
        wait_drained();

        write_cfg(32'hffff_ffff, 16'd3);
        queue_random(100, 50, 3);
        wait_drained();

        // last part runs without idling
        write_cfg(32'h7fff_ffff, 16'd7);
        quiet = 1'b1;
        queue_random(60, 50, 2);
        wait_drained();

        repeat (40) @(posedge i_clk);
        if (fail_cnt == 0 && outstanding_results.size() == 0)
            $display("** timer_deadline_queue: PASSED **");
        else
            $display("** timer_deadline_queue: FAILED **");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("** timer_deadline_queue: FAILED **");
        $finish;
    end

endmodule
